// ===== hw/rtl/nts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nts_pkg
// Shared widths, request codes, state type and control structs of the
// target snap block.
// ----------------------------------------------------------------------------
package nts_pkg;

	localparam int COORD_W      = 24;  // stored targets, rectangle corner
	localparam int SIZE_W       = 23;  // width, height, threshold
	localparam int OUT_W        = 25;  // corrected move
	localparam int SUM_W        = 25;  // corner plus size before saturation
	localparam int SRC_W        = 26;  // moved source points
	localparam int DIFF_W       = 28;  // target minus source
	localparam int TYPE_W       = 2;
	localparam int SRC_SEL_W    = 2;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam int TARGET_DEPTH = 256;
	localparam int THR_RESET    = 80;

	localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_ADD   = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

	// source point order: low edge, center, high edge
	localparam logic [SRC_SEL_W-1:0] SRC_LOW  = 2'd0;
	localparam logic [SRC_SEL_W-1:0] SRC_MID  = 2'd1;
	localparam logic [SRC_SEL_W-1:0] SRC_HIGH = 2'd2;

	// target pair order on add: low edge, high edge, center
	localparam logic [SRC_SEL_W-1:0] PAIR_LOW  = 2'd0;
	localparam logic [SRC_SEL_W-1:0] PAIR_HIGH = 2'd1;
	localparam logic [SRC_SEL_W-1:0] PAIR_MID  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                 load;
		logic                 wr;
		logic [SRC_SEL_W-1:0] wr_sel;
		logic                 rd_en;
		logic [SRC_SEL_W-1:0] rd_src;
		logic                 finish;
	} cmd_t;

	typedef struct packed {
		logic skip;      // query needs no scan
		logic out_free;  // result register can take a word
	} sts_t;

endpackage

// ===== hw/rtl/nts_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nts_req_if / nts_rsp_if
// Valid-ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface nts_req_if;
	logic                                   valid;
	logic                                   ready;
	logic        [nts_pkg::TYPE_W-1:0]      req_type;
	logic signed [nts_pkg::COORD_W-1:0]     rect_x;
	logic signed [nts_pkg::COORD_W-1:0]     rect_y;
	logic        [nts_pkg::SIZE_W-1:0]      rect_w;
	logic        [nts_pkg::SIZE_W-1:0]      rect_h;
	logic signed [nts_pkg::COORD_W-1:0]     move_dx;
	logic signed [nts_pkg::COORD_W-1:0]     move_dy;

	modport source (output valid, req_type, rect_x, rect_y, rect_w, rect_h,
		move_dx, move_dy, input ready);
	modport sink (input valid, req_type, rect_x, rect_y, rect_w, rect_h,
		move_dx, move_dy, output ready);
endinterface

interface nts_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [nts_pkg::OUT_W-1:0]   out_dx;
	logic signed [nts_pkg::OUT_W-1:0]   out_dy;
	logic                               snapped_x;
	logic                               snapped_y;
	logic signed [nts_pkg::COORD_W-1:0] guide_x;
	logic signed [nts_pkg::COORD_W-1:0] guide_y;
	logic                               status;

	modport source (output valid, out_dx, out_dy, snapped_x, snapped_y,
		guide_x, guide_y, status, input ready);
	modport sink (input valid, out_dx, out_dy, snapped_x, snapped_y,
		guide_x, guide_y, status, output ready);
endinterface

// ===== hw/rtl/nts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nts_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/nts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nts_ctrl
// Sequencer: accepts a word, runs the target writes or the store scan,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module nts_ctrl #(
	parameter int DEPTH = nts_pkg::TARGET_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [nts_pkg::TYPE_W-1:0]  in_type,
	output logic                        in_ready,
	input  nts_pkg::sts_t               sts,
	input  logic [$clog2(DEPTH+1)-1:0]  count,
	output nts_pkg::cmd_t               cmd,
	output logic [$clog2(DEPTH)-1:0]    rd_addr
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	nts_pkg::state_t                 state_q, state_d;
	logic [AW-1:0]                   idx_q, idx_d;
	logic [nts_pkg::SRC_SEL_W-1:0]   sel_q, sel_d;
	logic                            drain_q, drain_d;
	logic                            last_entry;

	assign last_entry = (CW'(idx_q) + CW'(1)) == count;
	assign rd_addr    = idx_q;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nts_pkg::ST_IDLE;
			idx_q   <= '0;
			sel_q   <= '0;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			sel_q   <= sel_d;
			drain_q <= drain_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		sel_d      = sel_q;
		drain_d    = drain_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.wr_sel = sel_q;
		cmd.rd_src = sel_q;
		unique case (state_q)
			nts_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				idx_d    = '0;
				sel_d    = '0;
				drain_d  = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_type == nts_pkg::REQ_ADD) begin
						state_d = nts_pkg::ST_WRITE;
					end else if (in_type == nts_pkg::REQ_QUERY && !sts.skip) begin
						state_d = nts_pkg::ST_SCAN;
					end else begin
						state_d = nts_pkg::ST_FINISH;
					end
				end
			end
			nts_pkg::ST_WRITE: begin
				cmd.wr = 1'b1;
				sel_d  = sel_q + 2'd1;
				if (sel_q == nts_pkg::PAIR_MID) begin
					state_d = nts_pkg::ST_FINISH;
				end
			end
			nts_pkg::ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (last_entry) begin
					idx_d = '0;
					sel_d = sel_q + 2'd1;
					if (sel_q == nts_pkg::SRC_HIGH) begin
						state_d = nts_pkg::ST_DRAIN;
					end
				end else begin
					idx_d = idx_q + AW'(1);
				end
			end
			nts_pkg::ST_DRAIN: begin
				// let the read and compare stages empty
				drain_d = 1'b1;
				if (drain_q) begin
					state_d = nts_pkg::ST_FINISH;
				end
			end
			nts_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = nts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nts_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (CW'(idx_q) < count))
		else $error("scan address beyond stored targets");
	a_finish_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == nts_pkg::ST_IDLE)
		else $error("finish did not return to idle");
	a_write_three: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nts_pkg::ST_WRITE && sel_q == nts_pkg::PAIR_LOW)
		|=> (state_q == nts_pkg::ST_WRITE) ##1 (state_q == nts_pkg::ST_WRITE))
		else $error("add did not write three pairs");
`endif

endmodule

// ===== hw/rtl/nts_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nts_dpath
// Target stores, distance pipeline, best-match tracking and result register.
// ----------------------------------------------------------------------------
module nts_dpath #(
	parameter int DEPTH = nts_pkg::TARGET_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  nts_pkg::cmd_t                      cmd,
	input  logic [$clog2(DEPTH)-1:0]           rd_addr,
	output nts_pkg::sts_t                      sts,
	output logic [$clog2(DEPTH+1)-1:0]         count,
	input  logic [nts_pkg::SIZE_W-1:0]         snap_threshold,
	input  logic                               snap_enable,
	input  logic [nts_pkg::TYPE_W-1:0]         req_type,
	input  logic signed [nts_pkg::COORD_W-1:0] rect_x,
	input  logic signed [nts_pkg::COORD_W-1:0] rect_y,
	input  logic [nts_pkg::SIZE_W-1:0]         rect_w,
	input  logic [nts_pkg::SIZE_W-1:0]         rect_h,
	input  logic signed [nts_pkg::COORD_W-1:0] move_dx,
	input  logic signed [nts_pkg::COORD_W-1:0] move_dy,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [nts_pkg::OUT_W-1:0]   out_dx,
	output logic signed [nts_pkg::OUT_W-1:0]   out_dy,
	output logic                               snapped_x,
	output logic                               snapped_y,
	output logic signed [nts_pkg::COORD_W-1:0] guide_x,
	output logic signed [nts_pkg::COORD_W-1:0] guide_y,
	output logic                               status
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int CRD = nts_pkg::COORD_W;
	localparam int SZ  = nts_pkg::SIZE_W;
	localparam int SW  = nts_pkg::SRC_W;
	localparam int DW  = nts_pkg::DIFF_W;
	localparam int UW  = nts_pkg::SUM_W;
	localparam int SLW = nts_pkg::SRC_SEL_W;

	// saturate a corner plus size to the coordinate range
	function automatic logic signed [CRD-1:0] sat_coord(input logic signed [UW-1:0] v);
		logic signed [CRD-1:0] r;
		if (v[UW-1] != v[UW-2]) begin
			r = v[UW-1] ? {1'b1, {(CRD-1){1'b0}}} : {1'b0, {(CRD-1){1'b1}}};
		end else begin
			r = v[CRD-1:0];
		end
		return r;
	endfunction

	// item registers
	logic [nts_pkg::TYPE_W-1:0] type_q;
	logic signed [CRD-1:0]      rx_q, ry_q, mdx_q, mdy_q;
	logic [SZ-1:0]              rw_q, rh_q;
	logic [CW-1:0]              count_q;
	logic                       dropped_q;
	logic                       scanned_q;

	// source points, refreshed each cycle from the held item
	logic signed [SW-1:0] srcx_q [3];
	logic signed [SW-1:0] srcy_q [3];
	logic signed [SW-1:0] nx, ny, wx, wy, hx, hy;

	// store write
	logic                  do_wr;
	logic signed [UW-1:0]  sumx, sumy;
	logic signed [CRD-1:0] wdx, wdy;

	// scan pipeline
	logic [CRD-1:0]        rdx, rdy;
	logic                  v_s1;
	logic [SLW-1:0]        src_s1;
	logic                  v_s2;
	logic [SLW-1:0]        src_s2;
	logic signed [DW-1:0]  dx_s2, dy_s2;
	logic [DW-1:0]         ax_s2, ay_s2;
	logic signed [CRD-1:0] tx_s2, ty_s2;
	logic signed [DW-1:0]  dx, dy;

	// best match so far
	logic                  fx_q, fy_q;
	logic [DW-1:0]         bax_q, bay_q;
	logic signed [DW-1:0]  box_q, boy_q;
	logic signed [CRD-1:0] btx_q, bty_q;
	logic [SLW-1:0]        bsx_q, bsy_q;
	logic                  take_x, take_y;
	logic                  hit_x, hit_y;

	assign count        = count_q;
	assign sts.skip     = !snap_enable || (count_q == '0);
	assign sts.out_free = !out_valid || out_ready;

	// hold the accepted word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			rx_q   <= rect_x;
			ry_q   <= rect_y;
			rw_q   <= rect_w;
			rh_q   <= rect_h;
			mdx_q  <= move_dx;
			mdy_q  <= move_dy;
		end
	end

	// moved source points
	assign nx = SW'(rx_q) + SW'(mdx_q);
	assign ny = SW'(ry_q) + SW'(mdy_q);
	assign wx = signed'({{(SW-SZ){1'b0}}, rw_q});
	assign wy = signed'({{(SW-SZ){1'b0}}, rh_q});
	assign hx = signed'({{(SW-SZ+1){1'b0}}, rw_q[SZ-1:1]});
	assign hy = signed'({{(SW-SZ+1){1'b0}}, rh_q[SZ-1:1]});

	always_ff @(posedge clk) begin
		srcx_q[nts_pkg::SRC_LOW]  <= nx;
		srcx_q[nts_pkg::SRC_MID]  <= nx + hx;
		srcx_q[nts_pkg::SRC_HIGH] <= nx + wx;
		srcy_q[nts_pkg::SRC_LOW]  <= ny;
		srcy_q[nts_pkg::SRC_MID]  <= ny + hy;
		srcy_q[nts_pkg::SRC_HIGH] <= ny + wy;
	end

	// target pair for this write step
	always_comb begin
		case (cmd.wr_sel)
			nts_pkg::PAIR_HIGH: begin
				sumx = UW'(rx_q) + signed'({{(UW-SZ){1'b0}}, rw_q});
				sumy = UW'(ry_q) + signed'({{(UW-SZ){1'b0}}, rh_q});
			end
			nts_pkg::PAIR_MID: begin
				sumx = UW'(rx_q) + signed'({{(UW-SZ+1){1'b0}}, rw_q[SZ-1:1]});
				sumy = UW'(ry_q) + signed'({{(UW-SZ+1){1'b0}}, rh_q[SZ-1:1]});
			end
			default: begin
				sumx = UW'(rx_q);
				sumy = UW'(ry_q);
			end
		endcase
		wdx = sat_coord(sumx);
		wdy = sat_coord(sumy);
	end

	assign do_wr = cmd.wr && (count_q < CW'(DEPTH));

	nts_ram #(.WIDTH(CRD), .DEPTH(DEPTH)) u_xram (
		.clk   (clk),
		.we    (do_wr),
		.waddr (count_q[AW-1:0]),
		.wdata (wdx),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rdx)
	);

	nts_ram #(.WIDTH(CRD), .DEPTH(DEPTH)) u_yram (
		.clk   (clk),
		.we    (do_wr),
		.waddr (count_q[AW-1:0]),
		.wdata (wdy),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rdy)
	);

	// fill count, drop flag and scan flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			scanned_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				dropped_q <= 1'b0;
				scanned_q <= 1'b0;
			end
			if (cmd.rd_en) begin
				scanned_q <= 1'b1;
			end
			if (do_wr) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.wr) begin
				dropped_q <= 1'b1;
			end
			if (cmd.finish && type_q == nts_pkg::REQ_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	// distance stage
	assign dx = DW'(signed'(rdx)) - DW'(srcx_q[src_s1]);
	assign dy = DW'(signed'(rdy)) - DW'(srcy_q[src_s1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		src_s1 <= cmd.rd_src;
		src_s2 <= src_s1;
		dx_s2  <= dx;
		dy_s2  <= dy;
		ax_s2  <= dx[DW-1] ? DW'(-dx) : DW'(dx);
		ay_s2  <= dy[DW-1] ? DW'(-dy) : DW'(dy);
		tx_s2  <= signed'(rdx);
		ty_s2  <= signed'(rdy);
	end

	// keep the nearest: distance, then earlier source, then smaller target
	assign take_x = v_s2 && (!fx_q || ax_s2 < bax_q ||
		(ax_s2 == bax_q && src_s2 == bsx_q && tx_s2 < btx_q));
	assign take_y = v_s2 && (!fy_q || ay_s2 < bay_q ||
		(ay_s2 == bay_q && src_s2 == bsy_q && ty_s2 < bty_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q <= 1'b0;
			fy_q <= 1'b0;
		end else if (cmd.load) begin
			fx_q <= 1'b0;
			fy_q <= 1'b0;
		end else begin
			fx_q <= fx_q || take_x;
			fy_q <= fy_q || take_y;
		end
	end

	always_ff @(posedge clk) begin
		if (take_x) begin
			bax_q <= ax_s2;
			box_q <= dx_s2;
			btx_q <= tx_s2;
			bsx_q <= src_s2;
		end
		if (take_y) begin
			bay_q <= ay_s2;
			boy_q <= dy_s2;
			bty_q <= ty_s2;
			bsy_q <= src_s2;
		end
	end

	assign hit_x = scanned_q && fx_q && (bax_q <= DW'(snap_threshold));
	assign hit_y = scanned_q && fy_q && (bay_q <= DW'(snap_threshold));

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_dx    <= '0;
			out_dy    <= '0;
			snapped_x <= 1'b0;
			snapped_y <= 1'b0;
			guide_x   <= '0;
			guide_y   <= '0;
			status    <= 1'b0;
			case (type_q)
				nts_pkg::REQ_ADD: begin
					status <= dropped_q;
				end
				nts_pkg::REQ_QUERY: begin
					out_dx <= hit_x ? nts_pkg::OUT_W'(DW'(mdx_q) + box_q)
						: nts_pkg::OUT_W'(mdx_q);
					out_dy <= hit_y ? nts_pkg::OUT_W'(DW'(mdy_q) + boy_q)
						: nts_pkg::OUT_W'(mdy_q);
					snapped_x <= hit_x;
					snapped_y <= hit_y;
					guide_x   <= hit_x ? btx_q : '0;
					guide_y   <= hit_y ? bty_q : '0;
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("target count beyond store depth");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && type_q == nts_pkg::REQ_CLEAR) |=> count_q == '0)
		else $error("clear left targets in store");
	a_snap_has_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && type_q == nts_pkg::REQ_QUERY && !scanned_q)
		|=> !snapped_x && !snapped_y)
		else $error("snap reported without a scan");
`endif

endmodule

// ===== hw/rtl/nearest_target_snap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_target_snap
// Snaps a moved rectangle to the nearest stored X and Y targets.
// ----------------------------------------------------------------------------
// One word at a time. A clear goes straight to the finish state; an add
// makes three pair writes through the single write port of each target RAM.
// A query scans the stored targets: the scan reads one entry of each store
// per cycle, once for each of the three source points, then a drain state
// lets the read and compare stages empty. A query with snapping disabled or
// an empty store skips the scan. A new word is taken while the previous
// result waits in the output register. Threshold and enable sit on the APB
// port at byte addresses 0 and 4.
module nearest_target_snap #(
	parameter int TARGET_DEPTH = nts_pkg::TARGET_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	nts_req_if.sink                           req,
	nts_rsp_if.source                         rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nts_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [nts_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [nts_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	localparam int AW = $clog2(TARGET_DEPTH);
	localparam int CW = $clog2(TARGET_DEPTH + 1);

	logic [nts_pkg::SIZE_W-1:0] thr_q;
	logic                       en_q;
	logic                       wr_fire;
	nts_pkg::cmd_t              cmd;
	nts_pkg::sts_t              sts;
	logic [AW-1:0]              rd_addr;
	logic [CW-1:0]              count;

	// configuration registers
	assign pready  = 1'b1;
	assign wr_fire = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= nts_pkg::SIZE_W'(nts_pkg::THR_RESET);
			en_q  <= 1'b1;
		end else if (wr_fire) begin
			if (paddr[2]) begin
				en_q <= pwdata[0];
			end else begin
				thr_q <= pwdata[nts_pkg::SIZE_W-1:0];
			end
		end
	end

	assign prdata = paddr[2] ? {{(nts_pkg::APB_DATA_W-1){1'b0}}, en_q}
		: {{(nts_pkg::APB_DATA_W-nts_pkg::SIZE_W){1'b0}}, thr_q};

	nts_ctrl #(.DEPTH(TARGET_DEPTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_type  (req.req_type),
		.in_ready (req.ready),
		.sts      (sts),
		.count    (count),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	nts_dpath #(.DEPTH(TARGET_DEPTH)) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.rd_addr        (rd_addr),
		.sts            (sts),
		.count          (count),
		.snap_threshold (thr_q),
		.snap_enable    (en_q),
		.req_type       (req.req_type),
		.rect_x         (req.rect_x),
		.rect_y         (req.rect_y),
		.rect_w         (req.rect_w),
		.rect_h         (req.rect_h),
		.move_dx        (req.move_dx),
		.move_dy        (req.move_dy),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.out_dx         (rsp.out_dx),
		.out_dy         (rsp.out_dy),
		.snapped_x      (rsp.snapped_x),
		.snapped_y      (rsp.snapped_y),
		.guide_x        (rsp.guide_x),
		.guide_y        (rsp.guide_y),
		.status         (rsp.status)
	);

endmodule

// ===== bench/nts_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nts_tb_pkg
// Register addresses and codes shared by the snap bench modules.
// ----------------------------------------------------------------------------
package nts_tb_pkg;

	localparam logic [nts_pkg::APB_ADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
	localparam logic [nts_pkg::APB_ADDR_W-1:0] ADDR_ENABLE    = 3'd4;
	localparam logic [nts_pkg::TYPE_W-1:0]     REQ_RSVD       = 2'd3;

endpackage

// ===== bench/nts_snap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nts_snap_checker
// Watches the request, result and register ports of the snap block, keeps
// its own target stores and settings, predicts each result word and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module nts_snap_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	nts_req_if                             req,
	nts_rsp_if                             rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [nts_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [nts_pkg::APB_DATA_W-1:0] pwdata,
	output int                             errors,
	output int                             pending
);
	import nts_pkg::*;
	import nts_tb_pkg::*;

	typedef struct {
		logic signed [OUT_W-1:0]   dx;
		logic signed [OUT_W-1:0]   dy;
		logic                      sx;
		logic                      sy;
		logic signed [COORD_W-1:0] gx;
		logic signed [COORD_W-1:0] gy;
		logic                      status;
	} snap_word_t;

	logic signed [COORD_W-1:0] x_tab [TARGET_DEPTH];
	logic signed [COORD_W-1:0] y_tab [TARGET_DEPTH];
	int unsigned               fill;
	logic [SIZE_W-1:0]         thr;
	logic                      en;
	snap_word_t                snap_q[$];
	int                        err_cnt;

	function automatic longint clamp_coord(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	function automatic void store_pair(longint xv, longint yv, inout bit dropped);
		if (fill < TARGET_DEPTH) begin
			x_tab[fill] = xv;
			y_tab[fill] = yv;
			fill++;
		end else begin
			dropped = 1'b1;
		end
	endfunction

	// per source: nearest, smaller target on tie; across sources: earlier wins
	function automatic bit nearest_on_axis(bit on_y, longint src[3],
			output longint off, output longint tgt);
		bit     found;
		bit     here_found;
		longint best, here_abs, here_off, here_tgt, t, d, a;
		found = 0;
		best = 0;
		off = 0;
		tgt = 0;
		for (int s = 0; s < 3; s++) begin
			here_found = 0;
			here_abs = 0;
			here_off = 0;
			here_tgt = 0;
			for (int i = 0; i < fill; i++) begin
				t = on_y ? longint'(y_tab[i]) : longint'(x_tab[i]);
				d = t - src[s];
				a = d < 0 ? -d : d;
				if (!here_found || a < here_abs || (a == here_abs && t < here_tgt)) begin
					here_found = 1;
					here_abs = a;
					here_off = d;
					here_tgt = t;
				end
			end
			if (here_found && (!found || here_abs < best)) begin
				found = 1;
				best = here_abs;
				off = here_off;
				tgt = here_tgt;
			end
		end
		return found;
	endfunction

	function automatic snap_word_t apply_word(logic [TYPE_W-1:0] kind, longint rx,
			longint ry, longint rw, longint rh, longint mdx, longint mdy);
		snap_word_t r;
		bit         dropped;
		longint     xs[3], ys[3], off, tgt, a;
		r = '{dx: '0, dy: '0, sx: 1'b0, sy: 1'b0, gx: '0, gy: '0, status: 1'b0};
		case (kind)
			REQ_CLEAR: begin
				fill = 0;
			end
			REQ_ADD: begin
				dropped = 0;
				store_pair(rx, ry, dropped);
				store_pair(clamp_coord(rx + rw), clamp_coord(ry + rh), dropped);
				store_pair(clamp_coord(rx + (rw >>> 1)), clamp_coord(ry + (rh >>> 1)),
					dropped);
				r.status = dropped;
			end
			REQ_QUERY: begin
				r.dx = mdx;
				r.dy = mdy;
				if (en && fill != 0) begin
					xs = '{rx + mdx, rx + mdx + (rw >>> 1), rx + mdx + rw};
					ys = '{ry + mdy, ry + mdy + (rh >>> 1), ry + mdy + rh};
					if (nearest_on_axis(0, xs, off, tgt)) begin
						a = off < 0 ? -off : off;
						if (a <= longint'(thr)) begin
							r.dx = mdx + off;
							r.gx = tgt;
							r.sx = 1'b1;
						end
					end
					if (nearest_on_axis(1, ys, off, tgt)) begin
						a = off < 0 ? -off : off;
						if (a <= longint'(thr)) begin
							r.dy = mdy + off;
							r.gy = tgt;
							r.sy = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// track settings, predict on accepted requests, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		snap_word_t e;
		if (!arst_n) begin
			fill = 0;
			thr = SIZE_W'(THR_RESET);
			en = 1'b1;
			snap_q.delete();
			err_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_THRESHOLD) thr = pwdata[SIZE_W-1:0];
				else if (paddr == ADDR_ENABLE) en = pwdata[0];
			end
			if (req.valid && req.ready)
				snap_q = {snap_q, apply_word(req.req_type, longint'(req.rect_x),
					longint'(req.rect_y), longint'(req.rect_w), longint'(req.rect_h),
					longint'(req.move_dx), longint'(req.move_dy))};
			if (rsp.valid && rsp.ready) begin
				if (snap_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: result word with nothing pending", $time);
				end else begin
					e = snap_q.pop_front();
					if (e.dx !== rsp.out_dx || e.dy !== rsp.out_dy || e.sx !== rsp.snapped_x
							|| e.sy !== rsp.snapped_y || e.gx !== rsp.guide_x
							|| e.gy !== rsp.guide_y || e.status !== rsp.status) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$display("%0t: mismatch exp dx=%0d dy=%0d sx=%0b sy=%0b gx=%0d gy=%0d st=%0b",
								$time, e.dx, e.dy, e.sx, e.sy, e.gx, e.gy, e.status);
							$display("%0t: mismatch got dx=%0d dy=%0d sx=%0b sy=%0b gx=%0d gy=%0d st=%0b",
								$time, rsp.out_dx, rsp.out_dy, rsp.snapped_x,
								rsp.snapped_y, rsp.guide_x, rsp.guide_y, rsp.status);
						end
					end
				end
			end
			errors <= err_cnt;
			pending <= snap_q.size();
		end
	end

endmodule

// ===== bench/nearest_target_snap_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_target_snap_test
// Drives directed and random clear, add and query words into the snap block
// under several threshold and enable settings and varied back pressure;
// a checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module nearest_target_snap_test;
	import nts_pkg::*;
	import nts_tb_pkg::*;

	localparam int HOLD_CYCLES    = 1500;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SEG_WORDS      = 205;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    errors;
	int                    pending;
	int                    send_idle = 0;
	int                    recv_idle = 0;
	int                    hold_req = 0;
	int                    hold_seen;
	int                    hold_left;
	int                    stall_cnt;
	longint                thr_now = THR_RESET;
	longint                aim_x[$];
	longint                aim_y[$];

	nts_req_if req_ch ();
	nts_rsp_if rsp_ch ();

	nearest_target_snap dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	nts_snap_checker checker_i (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.pready (pready),
		.paddr  (paddr),
		.pwdata (pwdata),
		.errors (errors),
		.pending(pending)
	);

	always #2 clk = ~clk;

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// end the run if no word moves for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cnt <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt == WATCHDOG_LIMIT) begin
				$display("[nearest_target_snap] ERROR");
				$finish;
			end
		end
	end

	task automatic send_word(logic [TYPE_W-1:0] kind, longint x, longint y, longint w,
			longint h, longint dx, longint dy);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.rect_x <= x;
		req_ch.rect_y <= y;
		req_ch.rect_w <= w;
		req_ch.rect_h <= h;
		req_ch.move_dx <= dx;
		req_ch.move_dy <= dy;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		// keep aiming points, one corner per add, emptied along with the block's stores
		if (kind == REQ_CLEAR) begin
			aim_x.delete();
			aim_y.delete();
		end else if (kind == REQ_ADD && aim_x.size() < TARGET_DEPTH) begin
			aim_x = {aim_x, x};
			aim_y = {aim_y, y};
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic longint rnd_coord();
		case ($urandom_range(3))
			0: return longint'($signed(24'($urandom)));
			1: return longint'($urandom_range(4000)) - 2000;
			2: case ($urandom_range(3))
				0: return 64'sd8388607;
				1: return -64'sd8388608;
				2: return 0;
				default: return -1;
			endcase
			default: return longint'($urandom_range(200000)) - 100000;
		endcase
	endfunction

	function automatic longint rnd_size();
		case ($urandom_range(3))
			0: return longint'($urandom & 32'h7FFFFF);
			1: return longint'($urandom_range(2000));
			2: return $urandom_range(1) ? 64'sd8388607 : longint'($urandom_range(1));
			default: return longint'($urandom_range(100000));
		endcase
	endfunction

	function automatic longint clamp_move(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	// query, mostly aimed so one source point lands near an added corner
	task automatic send_aimed_query();
		longint x, y, w, h, span, dx, dy;
		int     k;
		x = longint'($urandom_range(4000)) - 2000;
		y = longint'($urandom_range(4000)) - 2000;
		w = $urandom_range(3) == 0 ? rnd_size() : longint'($urandom_range(600));
		h = $urandom_range(3) == 0 ? rnd_size() : longint'($urandom_range(600));
		if (aim_x.size() == 0 || $urandom_range(9) == 0) begin
			send_word(REQ_QUERY, x, y, w, h, rnd_coord(), rnd_coord());
		end else begin
			span = thr_now > 200 ? 200 : thr_now + 8;
			k = $urandom_range(aim_x.size() - 1);
			dx = aim_x[k] - x + longint'($urandom_range(2 * span)) - span;
			dy = aim_y[k] - y + longint'($urandom_range(2 * span)) - span;
			case ($urandom_range(2))
				1: begin dx -= w >>> 1; dy -= h >>> 1; end
				2: begin dx -= w; dy -= h; end
				default: ;
			endcase
			send_word(REQ_QUERY, x, y, w, h, clamp_move(dx), clamp_move(dy));
		end
	endtask

	// mostly well-formed sequences: clear, adds, aimed queries; some noise
	task automatic random_words(int count, bit fill_first);
		int sent, adds;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(19) == 0) begin
				send_word(2'($urandom), rnd_coord(), rnd_coord(), rnd_size(), rnd_size(),
					rnd_coord(), rnd_coord());
				sent++;
			end else begin
				if ($urandom_range(4) != 0) begin
					send_word(REQ_CLEAR, rnd_coord(), rnd_coord(), rnd_size(), rnd_size(),
						rnd_coord(), rnd_coord());
					sent++;
				end
				case ($urandom_range(99))
					0, 1, 2: adds = $urandom_range(86, 92);
					3, 4, 5, 6, 7, 8, 9: adds = $urandom_range(20, 40);
					default: adds = $urandom_range(1, 6);
				endcase
				if (fill_first) adds = 90;
				fill_first = 0;
				repeat (adds) begin
					if ($urandom_range(3) == 0)
						send_word(REQ_ADD, rnd_coord(), rnd_coord(), rnd_size(), rnd_size(),
							rnd_coord(), rnd_coord());
					else
						send_word(REQ_ADD, longint'($urandom_range(8000)) - 4000,
							longint'($urandom_range(8000)) - 4000, $urandom_range(1000),
							$urandom_range(1000), 0, 0);
					sent++;
				end
				repeat ($urandom_range(2, 8)) begin
					send_aimed_query();
					sent++;
				end
			end
		end
	endtask

	initial begin
		longint thr_set [6];
		bit     en_set [6];
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_CLEAR;
		req_ch.rect_x = '0;
		req_ch.rect_y = '0;
		req_ch.rect_w = '0;
		req_ch.rect_h = '0;
		req_ch.move_dx = '0;
		req_ch.move_dy = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, reserved code, canvas, threshold edges
		send_word(REQ_QUERY, 10, 10, 5, 5, 3, -3);
		send_word(REQ_RSVD, -8388608, 8388607, 8388607, 8388607, -8388608, 8388607);
		send_word(REQ_ADD, 0, 0, 16000, 9000, 0, 0);
		send_word(REQ_QUERY, 100, 100, 160, 160, -100, -100);
		send_word(REQ_QUERY, 0, 0, 32, 32, 70, -75);
		send_word(REQ_QUERY, 0, 0, 0, 0, 81, -81);
		send_word(REQ_QUERY, 0, 0, 0, 0, 80, -80);
		// saturated high edge and center, then the lowest corner
		send_word(REQ_ADD, 8388600, 8388600, 8388607, 8388607, 0, 0);
		send_word(REQ_ADD, -8388608, -8388608, 0, 0, 0, 0);
		send_word(REQ_QUERY, -8388608, -8388608, 8388607, 8388607, 8388607, -8388608);
		send_word(REQ_QUERY, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
		// equal distance to two targets: smaller target wins
		send_word(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
		send_word(REQ_ADD, 0, 0, 0, 0, 0, 0);
		send_word(REQ_ADD, 20, 20, 0, 0, 0, 0);
		send_word(REQ_ADD, 20, 20, 0, 0, 0, 0);
		send_word(REQ_QUERY, 10, 10, 0, 0, 0, 0);
		// equal distance from two sources: earlier source wins
		send_word(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
		send_word(REQ_ADD, 100, 100, 0, 0, 0, 0);
		send_word(REQ_ADD, 140, 140, 0, 0, 0, 0);
		send_word(REQ_QUERY, 0, 0, 40, 40, 95, 95);
		send_word(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
		send_word(REQ_QUERY, 5, 5, 5, 5, 5, 5);
		wait_drained();

		thr_set = '{0, 8388607, 80, longint'($urandom & 32'h7FFFFF), 1, 500};
		en_set = '{1, 1, 0, 1, 1, 1};
		for (int seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin send_idle = 15; recv_idle = 88; end
				1: begin send_idle = 88; recv_idle = 15; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			thr_now = thr_set[seg];
			write_reg(ADDR_THRESHOLD, APB_DATA_W'(thr_set[seg]));
			write_reg(ADDR_ENABLE, APB_DATA_W'(en_set[seg]));
			// back the block up behind a stalled result port
			if (seg == 0) hold_req <= hold_req + 1;
			random_words(SEG_WORDS, seg == 0);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[nearest_target_snap] OK");
		else
			$display("[nearest_target_snap] ERROR");
		$finish;
	end

endmodule
